FILE: design/dpu_pkg.sv
// ----------------------------------------------------------------------------
// dpu_pkg
// Shared types, codes and constants of the DIB pixel unpacker.
// ----------------------------------------------------------------------------
package dpu_pkg;

  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int MAX_HEIGHT_DEF = 4096;
  localparam int QUEUE_DEPTH    = 2;
  localparam int IDX_W          = 24;
  localparam int CFG_DATA_W     = 13;
  localparam int DIM_LIM_W      = 17;

  localparam logic [CFG_DATA_W-1:0] WIDTH_RESET  = 13'd320;
  localparam logic [CFG_DATA_W-1:0] HEIGHT_RESET = 13'd240;
  localparam logic [7:0]            ALPHA_OPAQUE = 8'hFF;

  typedef enum logic [1:0] {
    MODE_4BIT  = 2'd0,
    MODE_8BIT  = 2'd1,
    MODE_16BIT = 2'd2,
    MODE_RGB   = 2'd3
  } pixel_mode_e;

  typedef enum logic [1:0] {
    REG_PIXEL_MODE   = 2'd0,
    REG_FRAME_WIDTH  = 2'd1,
    REG_FRAME_HEIGHT = 2'd2
  } cfg_reg_e;

  // One queued byte result: one pixel, or a nibble pair in 4-bit mode
  typedef struct packed {
    logic [31:0]      value;
    logic [3:0]       lo_nib;
    logic             two;
    logic             eof;
    logic [IDX_W-1:0] pos;
  } token_t;

  // Zero reads as one, anything above the limit saturates
  function automatic logic [DIM_LIM_W-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] v,
                                                     input logic [DIM_LIM_W-1:0]  lim);
    logic [DIM_LIM_W-1:0] ext;
    ext = DIM_LIM_W'(v);
    if (ext == '0) begin
      return DIM_LIM_W'(1);
    end else if (ext > lim) begin
      return lim;
    end
    return ext;
  endfunction

endpackage

FILE: design/dpu_intf.sv
// ----------------------------------------------------------------------------
// dpu_intf
// Valid/ready channels of the DIB pixel unpacker: raw bytes, pixels, config.
// ----------------------------------------------------------------------------
interface dpu_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface dpu_pix_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_value;
  logic [23:0] pixel_index;
  logic        end_of_frame;
  logic        last_of_item;

  modport source (output valid, output pixel_value, output pixel_index,
                  output end_of_frame, output last_of_item, input ready);
  modport sink   (input valid, input pixel_value, input pixel_index,
                  input end_of_frame, input last_of_item, output ready);
endinterface

interface dpu_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  reg_index;
  logic [12:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

FILE: design/dpu_front.sv
// ----------------------------------------------------------------------------
// dpu_front
// Config registers and byte classifier: tracks column, row and padding,
// assembles multi-byte pixels and pushes one token per producing word.
// ----------------------------------------------------------------------------
module dpu_front #(
  parameter int MAX_WIDTH  = dpu_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = dpu_pkg::MAX_HEIGHT_DEF,
  localparam int WW = $clog2(MAX_WIDTH + 1),
  localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  dpu_cfg_if.sink          cfg_ch,
  dpu_byte_if.sink         in_ch,
  input  logic             full_i,
  output logic             push_o,
  output dpu_pkg::token_t  tok_o,
  output logic             flip_o,
  output logic [WW-1:0]    width_o,
  output logic [HW-1:0]    height_o
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  dpu_pkg::pixel_mode_e mode_q, mode_d;
  logic [WW-1:0]  width_q, width_d;
  logic [HW-1:0]  height_q, height_d;
  logic [1:0]     phase_q, phase_d;
  logic [15:0]    held_q, held_d;
  logic [CW-1:0]  col_q, col_d;
  logic [RW-1:0]  row_q, row_d;
  logic [dpu_pkg::IDX_W-1:0] racc_q, racc_d;
  logic [1:0]     pad_q, pad_d;

  logic           cfg_wr, restart, acc, flip, have, two, last_done, end_row;
  logic [CW-1:0]  w_m1, last_col;
  logic [RW-1:0]  h_m1;
  logic [2:0]     wp1;
  logic [1:0]     row_bytes_lo, row_pad;
  logic [7:0]     b;

  assign cfg_ch.ready = 1'b1;
  // hold bytes off while a config word is offered
  assign in_ch.ready  = !full_i && !cfg_ch.valid;
  assign cfg_wr = cfg_ch.valid && cfg_ch.ready;
  assign acc    = in_ch.valid && in_ch.ready;
  assign b      = in_ch.data_byte;
  assign flip   = (mode_q == dpu_pkg::MODE_4BIT) || (mode_q == dpu_pkg::MODE_8BIT);
  assign w_m1   = CW'(width_q - WW'(1));
  assign h_m1   = RW'(height_q - HW'(1));

  // 4-bit rows hold ceil(width/2) bytes; 4/8-bit rows pad to a multiple of 4 bytes
  assign wp1          = width_q[2:0] + 3'd1;
  assign row_bytes_lo = (mode_q == dpu_pkg::MODE_4BIT) ? wp1[2:1] : width_q[1:0];
  assign row_pad      = flip ? (2'd0 - row_bytes_lo) : 2'd0;

  assign flip_o   = flip;
  assign width_o  = width_q;
  assign height_o = height_q;

  always_comb begin
    mode_d    = mode_q;
    width_d   = width_q;
    height_d  = height_q;
    phase_d   = phase_q;
    held_d    = held_q;
    col_d     = col_q;
    row_d     = row_q;
    racc_d    = racc_q;
    pad_d     = pad_q;
    restart   = 1'b0;
    have      = 1'b0;
    two       = 1'b0;
    end_row   = 1'b0;
    last_col  = col_q;
    last_done = 1'b0;
    push_o    = 1'b0;
    tok_o     = '0;
    tok_o.pos = flip ? (dpu_pkg::IDX_W'(col_q) - racc_q) : (racc_q + dpu_pkg::IDX_W'(col_q));

    if (cfg_wr) begin
      case (dpu_pkg::cfg_reg_e'(cfg_ch.reg_index))
        dpu_pkg::REG_PIXEL_MODE: begin
          mode_d  = dpu_pkg::pixel_mode_e'(cfg_ch.wdata[1:0]);
          restart = 1'b1;
        end
        dpu_pkg::REG_FRAME_WIDTH: begin
          width_d = WW'(dpu_pkg::clamp_dim(cfg_ch.wdata, dpu_pkg::DIM_LIM_W'(MAX_WIDTH)));
          restart = 1'b1;
        end
        dpu_pkg::REG_FRAME_HEIGHT: begin
          height_d = HW'(dpu_pkg::clamp_dim(cfg_ch.wdata, dpu_pkg::DIM_LIM_W'(MAX_HEIGHT)));
          restart  = 1'b1;
        end
        default: begin
          restart = 1'b0;
        end
      endcase
    end else if (acc) begin
      if (flip && (pad_q != 2'd0)) begin
        // drop padding; the last pad byte closes the row
        pad_d   = pad_q - 2'd1;
        end_row = (pad_q == 2'd1);
      end else begin
        case (mode_q)
          dpu_pkg::MODE_4BIT: begin
            have         = 1'b1;
            two          = (col_q != w_m1);
            tok_o.value  = {28'd0, b[7:4]};
            tok_o.lo_nib = b[3:0];
          end
          dpu_pkg::MODE_8BIT: begin
            have        = 1'b1;
            tok_o.value = {24'd0, b};
          end
          dpu_pkg::MODE_16BIT: begin
            if (phase_q == 2'd0) begin
              held_d  = {8'd0, b};
              phase_d = 2'd1;
            end else begin
              phase_d     = 2'd0;
              have        = 1'b1;
              tok_o.value = {16'd0, b, held_q[7:0]};
            end
          end
          default: begin
            if (phase_q == 2'd0) begin
              held_d  = {b, 8'd0};
              phase_d = 2'd1;
            end else if (phase_q == 2'd1) begin
              held_d  = {held_q[15:8], b};
              phase_d = 2'd2;
            end else begin
              phase_d     = 2'd0;
              have        = 1'b1;
              tok_o.value = {dpu_pkg::ALPHA_OPAQUE, held_q[15:8], held_q[7:0], b};
            end
          end
        endcase

        if (have) begin
          last_col  = col_q + CW'(two);
          last_done = (last_col == w_m1);
          tok_o.two = two;
          tok_o.eof = last_done && (row_q == h_m1);
          push_o    = 1'b1;
          if (last_done) begin
            if (row_pad != 2'd0) begin
              col_d = '0;
              pad_d = row_pad;
            end else begin
              end_row = 1'b1;
            end
          end else begin
            col_d = last_col + CW'(1);
          end
        end
      end

      if (end_row) begin
        col_d  = '0;
        pad_d  = 2'd0;
        row_d  = row_q + RW'(1);
        racc_d = racc_q + dpu_pkg::IDX_W'(width_q);
        if (row_q == h_m1) begin
          restart = 1'b1;
        end
      end
    end

    if (restart) begin
      phase_d = 2'd0;
      held_d  = '0;
      col_d   = '0;
      row_d   = '0;
      racc_d  = '0;
      pad_d   = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= dpu_pkg::MODE_RGB;
      width_q  <= WW'(dpu_pkg::clamp_dim(dpu_pkg::WIDTH_RESET,
                                         dpu_pkg::DIM_LIM_W'(MAX_WIDTH)));
      height_q <= HW'(dpu_pkg::clamp_dim(dpu_pkg::HEIGHT_RESET,
                                         dpu_pkg::DIM_LIM_W'(MAX_HEIGHT)));
      phase_q  <= 2'd0;
      held_q   <= '0;
      col_q    <= '0;
      row_q    <= '0;
      racc_q   <= '0;
      pad_q    <= 2'd0;
    end else begin
      mode_q   <= mode_d;
      width_q  <= width_d;
      height_q <= height_d;
      phase_q  <= phase_d;
      held_q   <= held_d;
      col_q    <= col_d;
      row_q    <= row_d;
      racc_q   <= racc_d;
      pad_q    <= pad_d;
    end
  end

endmodule

FILE: design/dpu_queue.sv
// ----------------------------------------------------------------------------
// dpu_queue
// Short token FIFO between classifier and pixel emitter.
// ----------------------------------------------------------------------------
module dpu_queue #(
  parameter int DEPTH = dpu_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  dpu_pkg::token_t tok_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            empty_o,
  output dpu_pkg::token_t head_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  dpu_pkg::token_t     mem_q [DEPTH];
  logic [PW-1:0]       wr_q, wr_d, rd_q, rd_d;
  logic [NW-1:0]       cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o  = (cnt_q == NW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + NW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= tok_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: design/dpu_back.sv
// ----------------------------------------------------------------------------
// dpu_back
// Pixel emitter: splits nibble pairs, resolves the flipped destination index
// and holds each pixel in the output register until taken.
// ----------------------------------------------------------------------------
module dpu_back #(
  parameter int MAX_WIDTH  = dpu_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = dpu_pkg::MAX_HEIGHT_DEF,
  localparam int WW = $clog2(MAX_WIDTH + 1),
  localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            flip_i,
  input  logic [WW-1:0]   width_i,
  input  logic [HW-1:0]   height_i,
  input  logic            empty_i,
  input  dpu_pkg::token_t head_i,
  output logic            pop_o,
  dpu_pix_if.source       out_ch
);

  localparam int PW = WW + HW;

  logic [PW-1:0]              prod;
  logic [dpu_pkg::IDX_W-1:0]  base_q, idx;
  logic                       vld_q, vld_d, sub_q, sub_d, load, take;
  logic [31:0]                val_q, val_d;
  logic [dpu_pkg::IDX_W-1:0]  pidx_q, pidx_d;
  logic                       eof_q, eof_d, last_q, last_d;

  // first destination row of a flipped frame: (height-1)*width
  assign prod = PW'(height_i - HW'(1)) * PW'(width_i);

  always_ff @(posedge clk_i) begin
    base_q <= dpu_pkg::IDX_W'(prod);
  end

  assign idx  = flip_i ? (base_q + head_i.pos) : head_i.pos;
  assign load = !vld_q || out_ch.ready;
  assign take = load && !empty_i;

  always_comb begin
    vld_d  = vld_q && !out_ch.ready;
    sub_d  = sub_q;
    val_d  = val_q;
    pidx_d = pidx_q;
    eof_d  = eof_q;
    last_d = last_q;
    pop_o  = 1'b0;
    if (take) begin
      vld_d = 1'b1;
      if (sub_q) begin
        // second nibble of the pair
        val_d  = {28'd0, head_i.lo_nib};
        pidx_d = idx + dpu_pkg::IDX_W'(1);
        eof_d  = head_i.eof;
        last_d = 1'b1;
        sub_d  = 1'b0;
        pop_o  = 1'b1;
      end else begin
        val_d  = head_i.value;
        pidx_d = idx;
        eof_d  = head_i.eof && !head_i.two;
        last_d = !head_i.two;
        sub_d  = head_i.two;
        pop_o  = !head_i.two;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      sub_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
      sub_q <= sub_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    pidx_q <= pidx_d;
    eof_q  <= eof_d;
    last_q <= last_d;
  end

  assign out_ch.valid        = vld_q;
  assign out_ch.pixel_value  = val_q;
  assign out_ch.pixel_index  = pidx_q;
  assign out_ch.end_of_frame = eof_q;
  assign out_ch.last_of_item = last_q;

  // pair in flight: its token stays at the head and the first half is shown
  a_sub_holds_head : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sub_q |-> (!empty_i && head_i.two && vld_q))
    else $error("nibble pair pending without its token at the queue head");

  a_first_half_pending : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && !last_q) |-> sub_q)
    else $error("first nibble shown without second pending");

  a_first_half_no_eof : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && !last_q) |-> !eof_q)
    else $error("end of frame flagged on first nibble of a pair");

endmodule

FILE: design/dib_pixel_unpacker.sv
// ----------------------------------------------------------------------------
// dib_pixel_unpacker
// Unpacks raw uncompressed frame bytes into pixels with destination index.
//
//   channel  dir  payload                                        accepted when
//   cfg_ch   in   reg_index[1:0], wdata[12:0]                    valid & ready
//   in_ch    in   data_byte[7:0]                                 valid & ready
//   out_ch   out  pixel_value[31:0], pixel_index[23:0],          valid & ready
//                 end_of_frame, last_of_item
//
// One byte a cycle is taken while in_ch is not stalled; a pixel is written to
// the token queue with its last byte, then loaded into the output register.
// A 4-bit byte giving two pixels holds the single output port for both in
// turn, so the output port paces that mode when every byte yields two.
// The token queue (two entries) lets bytes keep flowing while out_ch stalls;
// in_ch stalls when that queue is full or while a config word is offered.
// Config is always ready; a write to one of the three registers takes effect
// on the next byte and restarts the frame. No clearing pass at reset.
// ----------------------------------------------------------------------------
module dib_pixel_unpacker #(
  parameter int MAX_WIDTH  = dpu_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = dpu_pkg::MAX_HEIGHT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dpu_cfg_if.sink     cfg_ch,
  dpu_byte_if.sink    in_ch,
  dpu_pix_if.source   out_ch
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  logic            push, pop, full, empty, flip;
  dpu_pkg::token_t tok, head;
  logic [WW-1:0]   width;
  logic [HW-1:0]   height;

  dpu_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_ch   (cfg_ch),
    .in_ch    (in_ch),
    .full_i   (full),
    .push_o   (push),
    .tok_o    (tok),
    .flip_o   (flip),
    .width_o  (width),
    .height_o (height)
  );

  dpu_queue #(
    .DEPTH (dpu_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .tok_i   (tok),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head)
  );

  dpu_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .flip_i   (flip),
    .width_i  (width),
    .height_i (height),
    .empty_i  (empty),
    .head_i   (head),
    .pop_o    (pop),
    .out_ch   (out_ch)
  );

endmodule
